>>> design/yaw_pitch_camera_basis_unit_defines.svh
// Assertion macros shared by the camera basis RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef YAW_PITCH_CAMERA_BASIS_UNIT_DEFINES_SVH
`define YAW_PITCH_CAMERA_BASIS_UNIT_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define YPCB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ypcb: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define YPCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ypcb: next-cycle check failed");

`endif

>>> design/ypcb_pkg.sv
// Package for the yaw/pitch camera basis unit: default sizes, sine
// polynomial coefficients and sequencer step codes. No dependencies.
`default_nettype none

package ypcb_pkg;

  // Default sizes of the angle and vector formats.
  localparam int ANGLE_BITS_DEF = 16;
  localparam int VEC_FRAC_DEF   = 14;

  // Sensitivity after reset, about 0.1 degree per count.
  localparam logic [15:0] SENS_RESET = 16'd4660;

  // Quarter-wave odd sine polynomial, unsigned Q30, lowest order first.
  localparam logic [31:0] SIN_COEF [7] = '{
    32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995,
    32'd172272, 32'd3864, 32'd61
  };
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  // Sequencer steps: two angle deltas, four sines of eight products
  // each, then four basis products.
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_DX   = 6'd0;
  localparam logic [STEP_W-1:0] STEP_DY   = 6'd1;
  localparam logic [STEP_W-1:0] STEP_SIN0 = 6'd2;
  localparam logic [STEP_W-1:0] STEP_QM0  = 6'd34;
  localparam logic [STEP_W-1:0] STEP_LAST = 6'd37;

  // Horner phases inside one sine evaluation.
  localparam logic [2:0] SIN_SQUARE = 3'd0;
  localparam logic [2:0] SIN_FINAL  = 3'd7;

endpackage

`default_nettype wire

>>> design/yaw_pitch_camera_basis_unit.sv
// Yaw/pitch camera basis unit. Input beats carry a mouse delta pair and a
// pitch-clamp flag; each accepted beat updates the stored yaw and pitch
// angles and produces one output beat with the front, right and up vectors.
// The work runs on one shared 32x32 multiplier under a step sequencer: two
// products for the angle deltas, eight per sine for four sines, and four for
// the basis products. Each product is formed in S_MUL and consumed in S_POST;
// out_tvalid is set when the last S_POST ends, and no new input beat is taken
// until the sequencer is idle. in_tready is high only while the sequencer is
// idle. The finished result sits in an output register, so the next input beat
// is accepted while it waits; if the receiver still stalls when the next result
// is done, the sequencer holds in its last step until the output register frees.
// The sensitivity register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the unit is idle, which the block does not enforce.
// Synchronous reset sets yaw to -90 degrees, pitch to 30 degrees, sensitivity
// to 4660, and empties the sequencer and output register.
// Depends on ypcb_pkg and yaw_pitch_camera_basis_unit_defines.svh.
`default_nettype none
`include "yaw_pitch_camera_basis_unit_defines.svh"

module yaw_pitch_camera_basis_unit
  import ypcb_pkg::*;
#(
  parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
  parameter int VECTOR_FRAC_BITS = VEC_FRAC_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // x_offset[11:0], y_offset[23:12], constrain_pitch[24], zero pad [31:25]
  input  logic [31:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // front_x[15:0], front_y[31:16], front_z[47:32], right_x[63:48],
  // right_z[79:64], up_x[95:80], up_y[111:96], up_z[127:112]
  output logic [127:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  localparam int A = ANGLE_BITS;
  localparam int F = VECTOR_FRAC_BITS;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  // Angle constants.
  localparam logic [A-1:0] YAW_RST   = A'(longint'(3) << (A - 2));
  localparam logic [A-1:0] PITCH_RST = A'(((longint'(1) << A) + 6) / 12);
  localparam longint LimInt = ((longint'(89) << A) + 180) / 360;
  localparam logic signed [A-1:0] PITCH_LIM = A'(LimInt);
  localparam logic signed [A-1:0] PITCH_NLIM = -PITCH_LIM;

  // Rounding constants.
  localparam logic [F:0]  VEC_ONE  = {1'b1, {F{1'b0}}};
  localparam logic [31:0] SIN_HALF = 32'(1) << (29 - F);
  localparam logic [63:0] QM_HALF  = 64'(1) << (F - 1);

  // Control registers.
  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [A-1:0]      yaw_r, yaw_nxt;
  logic [A-1:0]      pitch_r, pitch_nxt;
  logic [15:0]       sens_r, sens_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  // Payload registers.
  logic [11:0]  xmag_r, ymag_r;
  logic         xneg_r, yneg_r, cons_r;
  logic [30:0]  x_r;
  logic [31:0]  x2_r;
  logic [31:0]  p_r;
  logic [1:0]   quad_r;
  logic [F:0]   smag_r [4];
  logic [3:0]   sneg_r;
  logic [F:0]   qmag_r [3];
  logic [63:0]  prod_r;
  logic [127:0] out_data_r;

  // Combinational helpers.
  logic [STEP_W-1:0] sidx, qidx;
  logic [1:0]   sj, qk, nxj;
  logic [2:0]   st, cidx;
  logic         is_sin;
  logic [31:0]  mul_a, mul_b;
  logic [31:0]  prod_hi, horner, s_cap, s_rnd;
  logic [F:0]   smag_new, qmag_new;
  logic [63:0]  q_sum;
  logic [A-1:0] x_ang;
  logic [1:0]   quad_nxt;
  logic [30:0]  x_lin, x_nxt;
  logic         d_neg;
  logic signed [31:0] d_val, d_sh;
  logic [A-1:0] d_ang, pitch_sum;
  logic         cp_neg, out_free, finish;
  logic [127:0] out_nxt;
  logic         chk_started, chk_dy_clamp, chk_pitch_ok, chk_sin_end, chk_out_wait;

  function automatic logic [15:0] vec16(input logic neg, input logic [F:0] mag);
    logic signed [31:0] v;
    v = $signed({{(31 - F){1'b0}}, mag});
    if (neg) begin
      v = -v;
    end
    return v[15:0];
  endfunction

  // Step decode.
  assign sidx   = step_r - STEP_SIN0;
  assign sj     = sidx[4:3];
  assign st     = sidx[2:0];
  assign qidx   = step_r - STEP_QM0;
  assign qk     = qidx[1:0];
  assign is_sin = (step_r >= STEP_SIN0) && (step_r < STEP_QM0);
  assign cidx   = 3'(3'd6 - st);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (step_r == STEP_DX) begin
      mul_a = 32'(xmag_r);
      mul_b = 32'(sens_r);
    end else if (step_r == STEP_DY) begin
      mul_a = 32'(ymag_r);
      mul_b = 32'(sens_r);
    end else if (is_sin) begin
      priority if (st == SIN_SQUARE) begin
        mul_a = 32'(x_r);
        mul_b = 32'(x_r);
      end else if (st == SIN_FINAL) begin
        mul_a = p_r;
        mul_b = 32'(x_r);
      end else begin
        mul_a = p_r;
        mul_b = x2_r;
      end
    end else begin
      unique case (qk)
        2'd0: begin mul_a = 32'(smag_r[1]); mul_b = 32'(smag_r[3]); end
        2'd1: begin mul_a = 32'(smag_r[0]); mul_b = 32'(smag_r[3]); end
        2'd2: begin mul_a = 32'(smag_r[1]); mul_b = 32'(smag_r[2]); end
        default: begin mul_a = 32'(smag_r[0]); mul_b = 32'(smag_r[2]); end
      endcase
    end
  end

  // Horner step, final sine scaling and basis product rounding.
  assign prod_hi  = prod_r[61:30];
  assign horner   = SIN_COEF[cidx] - prod_hi;
  assign s_cap    = (prod_hi > Q30_ONE) ? Q30_ONE : prod_hi;
  assign s_rnd    = (s_cap + SIN_HALF) >> (30 - F);
  assign smag_new = s_rnd[F:0];
  assign q_sum    = prod_r + QM_HALF;
  assign qmag_new = q_sum[2*F:F];

  // Sine argument for the next sine: yaw, yaw + quarter, pitch, pitch + quarter.
  assign nxj      = (step_r == STEP_DY) ? 2'd0 : 2'(sj + 2'd1);
  assign x_ang    = nxj[1] ? pitch_r : yaw_r;
  assign quad_nxt = x_ang[A-1:A-2] + {1'b0, nxj[0]};
  assign x_lin    = {1'b0, x_ang[A-3:0], {(32 - A){1'b0}}};
  assign x_nxt    = quad_nxt[0] ? (31'(Q30_ONE) - x_lin) : x_lin;

  // Scaled mouse delta, floored, wrapped onto the angle.
  assign d_neg = (step_r == STEP_DX) ? xneg_r : yneg_r;
  assign d_val = d_neg ? -$signed({4'b0, prod_r[27:0]}) : $signed({4'b0, prod_r[27:0]});
  assign d_sh  = d_val >>> 8;
  assign d_ang = d_sh[A-1:0];
  assign pitch_sum = pitch_r + d_ang;

  // Output assembly; the last basis product is taken straight from the multiplier.
  assign cp_neg = sneg_r[3] && (smag_r[3] != '0);
  assign out_nxt = {
    vec16(sneg_r[0] ^ sneg_r[2] ^ ~cp_neg, qmag_new),
    vec16(sneg_r[3] ^ cp_neg, smag_r[3]),
    vec16(sneg_r[1] ^ sneg_r[2] ^ ~cp_neg, qmag_r[2]),
    vec16(sneg_r[1] ^ cp_neg, smag_r[1]),
    vec16(sneg_r[0] ^ ~cp_neg, smag_r[0]),
    vec16(sneg_r[0] ^ sneg_r[3], qmag_r[1]),
    vec16(sneg_r[2], smag_r[2]),
    vec16(sneg_r[1] ^ sneg_r[3], qmag_r[0])
  };

  assign out_free = !out_tvalid_r || out_tready;
  assign finish   = (state_r == S_POST) && (step_r == STEP_LAST) && out_free;

  // Sequencer and angle state.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    yaw_nxt        = yaw_r;
    pitch_nxt      = pitch_r;
    sens_nxt       = cfg_wr_en ? cfg_wr_data : sens_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_MUL;
          step_nxt  = STEP_DX;
        end
      end
      S_MUL: begin
        state_nxt = S_POST;
      end
      S_POST: begin
        if (step_r == STEP_DX) begin
          yaw_nxt = yaw_r + d_ang;
        end
        if (step_r == STEP_DY) begin
          pitch_nxt = pitch_sum;
          if (cons_r) begin
            priority if ($signed(pitch_sum) > PITCH_LIM) begin
              pitch_nxt = PITCH_LIM;
            end else if ($signed(pitch_sum) < PITCH_NLIM) begin
              pitch_nxt = PITCH_NLIM;
            end else begin
              pitch_nxt = pitch_sum;
            end
          end
        end
        if (step_r == STEP_LAST) begin
          if (out_free) begin
            state_nxt      = S_IDLE;
            out_tvalid_nxt = 1'b1;
          end
        end else begin
          state_nxt = S_MUL;
          step_nxt  = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= STEP_DX;
      yaw_r        <= YAW_RST;
      pitch_r      <= PITCH_RST;
      sens_r       <= SENS_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      yaw_r        <= yaw_nxt;
      pitch_r      <= pitch_nxt;
      sens_r       <= sens_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Datapath registers: operand capture, multiplier and step results.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      xneg_r <= in_tdata[11];
      xmag_r <= in_tdata[11] ? 12'(-in_tdata[11:0]) : in_tdata[11:0];
      yneg_r <= in_tdata[23];
      ymag_r <= in_tdata[23] ? 12'(-in_tdata[23:12]) : in_tdata[23:12];
      cons_r <= in_tdata[24];
    end
    if (state_r == S_MUL) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == S_POST) begin
      if (step_r == STEP_DY) begin
        x_r    <= x_nxt;
        quad_r <= quad_nxt;
      end
      if (is_sin) begin
        priority if (st == SIN_SQUARE) begin
          x2_r <= prod_hi;
          p_r  <= SIN_COEF[6];
        end else if (st == SIN_FINAL) begin
          smag_r[sj] <= smag_new;
          sneg_r[sj] <= quad_r[1];
          x_r        <= x_nxt;
          quad_r     <= quad_nxt;
        end else begin
          p_r <= horner;
        end
      end
      if (step_r == STEP_QM0) begin
        qmag_r[0] <= qmag_new;
      end
      if (step_r == STEP_QM0 + 6'd1) begin
        qmag_r[1] <= qmag_new;
      end
      if (step_r == STEP_QM0 + 6'd2) begin
        qmag_r[2] <= qmag_new;
      end
    end
    if (finish) begin
      out_data_r <= out_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Conditions watched by the checks below.
  assign chk_started  = (state_r == S_MUL) && (step_r == STEP_DX);
  assign chk_dy_clamp = (state_r == S_POST) && (step_r == STEP_DY) && cons_r;
  assign chk_pitch_ok = ($signed(pitch_r) <= PITCH_LIM) && ($signed(pitch_r) >= PITCH_NLIM);
  assign chk_sin_end  = (state_r == S_POST) && is_sin && (st == SIN_FINAL);
  assign chk_out_wait = (state_r == S_POST) && (step_r == STEP_LAST) && out_tvalid_r &&
                        !out_tready;

  // Checks on the sequencer and datapath.
  `YPCB_ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, chk_started)
  `YPCB_ASSERT_SAME(a_step_bound, state_r != S_IDLE, step_r <= STEP_LAST)
  `YPCB_ASSERT_NEXT(a_pitch_clamped, chk_dy_clamp, chk_pitch_ok)
  `YPCB_ASSERT_SAME(a_sine_range, chk_sin_end, smag_new <= VEC_ONE)
  `YPCB_ASSERT_NEXT(a_result_held, chk_out_wait, (state_r == S_POST) && $stable(out_data_r))

endmodule

`default_nettype wire
